// ----- hdl/cpt_pkg.sv -----
// shared widths, types and helpers for the closest-point-on-triangle pipeline
`default_nettype none
package cpt_pkg;

  // field and bus widths
  localparam int COORD_W   = 32;
  localparam int NUM_COORD = 3;
  localparam int IN_W      = 12 * COORD_W;
  localparam int OUT_W     = NUM_COORD * COORD_W;

  // exact intermediate widths
  localparam int DIFF_W    = COORD_W + 1;
  localparam int LIMB_STEP = 32;
  localparam int LIMB_W    = LIMB_STEP + 1;
  localparam int PP_W      = 2 * LIMB_W;
  localparam int DOT_W     = 2 * DIFF_W + 2;
  localparam int PROD_W    = 2 * DOT_W;
  localparam int DET_W     = PROD_W + 1;
  localparam int EDGE_W    = DOT_W + 1;
  localparam int DEN_W     = DET_W + 2;
  localparam int NUM_W     = DIFF_W + DET_W + 1;
  localparam int Q_W       = COORD_W + 1;
  localparam int REM_W     = DEN_W + Q_W;
  localparam int WIDE_W    = 192;
  localparam int DET_LIMBS = 3;
  localparam int S_LIMBS   = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PP_W-1:0]    pp_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [DEN_W-1:0]   den_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  localparam coord_t COORD_MAX = 32'sh7FFFFFFF;
  localparam coord_t COORD_MIN = 32'sh80000000;

  // one lane handed to the divider
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic signed [COORD_W-1:0] base;
    logic force_base;
  } div_in_t;

  // 33-bit signed limb k of a sign-extended wide value; the top limb keeps the sign
  function automatic logic signed [LIMB_W-1:0] limb(input logic [WIDE_W-1:0] x,
                                                    input int k, input int nl);
    logic signed [LIMB_W-1:0] r;
    if (k == nl - 1) begin
      r = x[LIMB_STEP*k +: LIMB_W];
    end else begin
      r = {1'b0, x[LIMB_STEP*k +: LIMB_STEP]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/cpt_div.sv -----
// pipelined restoring divider with base add and saturation, three lanes
`default_nettype none
module cpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  cpt_pkg::div_in_t [2:0]        in_lane,
  output logic                          out_vld,
  output logic [cpt_pkg::OUT_W-1:0]     out_res
);

  localparam int NS  = cpt_pkg::Q_W;
  localparam int RW  = cpt_pkg::REM_W;
  localparam int DW  = cpt_pkg::DEN_W;
  localparam int NW  = cpt_pkg::NUM_W;
  localparam int SW  = cpt_pkg::Q_W + 2;

  logic [NS:0]                 vld_r;
  logic [RW-1:0]               rem_r  [0:NS][3];
  logic [RW-1:0]               rem_nxt[1:NS][3];
  logic [RW-1:0]               rem0_nxt[3];
  logic [DW-1:0]               dv_r   [0:NS][3];
  logic [DW-1:0]               dv_nxt [3];
  logic [NS-1:0]               q_r    [0:NS][3];
  logic [NS-1:0]               q_nxt  [1:NS][3];
  logic                        neg_r  [0:NS][3];
  logic                        neg_nxt[3];
  logic                        ovf_r  [0:NS][3];
  logic                        ovf_nxt[3];
  cpt_pkg::coord_t             base_r [0:NS][3];
  logic                        out_vld_r;
  logic [cpt_pkg::OUT_W-1:0]   out_res_r;
  logic [cpt_pkg::OUT_W-1:0]   out_res_nxt;

  // magnitudes, quotient sign and overflow test
  always_comb begin
    logic [NW-1:0] nm;
    logic [DW-1:0] dm;
    for (int l = 0; l < 3; l++) begin
      nm = in_lane[l].num[NW-1] ? NW'(-in_lane[l].num) : in_lane[l].num;
      dm = in_lane[l].den[DW-1] ? DW'(-in_lane[l].den) : in_lane[l].den;
      if (in_lane[l].force_base) begin
        nm = '0;
        dm = DW'(1);
      end
      rem0_nxt[l]   = RW'(nm);
      dv_nxt[l]     = dm;
      neg_nxt[l]    = (in_lane[l].num[NW-1] ^ in_lane[l].den[DW-1]) & ~in_lane[l].force_base;
      ovf_nxt[l]    = RW'(nm) >= (RW'(dm) << NS);
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [RW-1:0] trial;
    for (int s = 1; s <= NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        trial = RW'(dv_r[s-1][l]) << (NS - s);
        if (rem_r[s-1][l] >= trial) begin
          rem_nxt[s][l] = rem_r[s-1][l] - trial;
          q_nxt[s][l]   = q_r[s-1][l] | (NS'(1) << (NS - s));
        end else begin
          rem_nxt[s][l] = rem_r[s-1][l];
          q_nxt[s][l]   = q_r[s-1][l];
        end
      end
    end
  end

  // signed quotient plus base, clamped to the coordinate range
  always_comb begin
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] sum;
    for (int l = 0; l < 3; l++) begin
      qs  = neg_r[NS][l] ? -$signed(SW'(q_r[NS][l])) : $signed(SW'(q_r[NS][l]));
      sum = SW'(base_r[NS][l]) + qs;
      if (ovf_r[NS][l]) begin
        out_res_nxt[cpt_pkg::COORD_W*l +: cpt_pkg::COORD_W] =
          neg_r[NS][l] ? cpt_pkg::COORD_MIN : cpt_pkg::COORD_MAX;
      end else if (sum > SW'(cpt_pkg::COORD_MAX)) begin
        out_res_nxt[cpt_pkg::COORD_W*l +: cpt_pkg::COORD_W] = cpt_pkg::COORD_MAX;
      end else if (sum < SW'(cpt_pkg::COORD_MIN)) begin
        out_res_nxt[cpt_pkg::COORD_W*l +: cpt_pkg::COORD_W] = cpt_pkg::COORD_MIN;
      end else begin
        out_res_nxt[cpt_pkg::COORD_W*l +: cpt_pkg::COORD_W] = sum[cpt_pkg::COORD_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NS-1:0], in_vld};
      out_vld_r <= vld_r[NS];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l]  <= rem0_nxt[l];
        q_r[0][l]    <= '0;
        dv_r[0][l]   <= dv_nxt[l];
        neg_r[0][l]  <= neg_nxt[l];
        ovf_r[0][l]  <= ovf_nxt[l];
        base_r[0][l] <= in_lane[l].base;
        for (int s = 1; s <= NS; s++) begin
          rem_r[s][l]  <= rem_nxt[s][l];
          q_r[s][l]    <= q_nxt[s][l];
          dv_r[s][l]   <= dv_r[s-1][l];
          neg_r[s][l]  <= neg_r[s-1][l];
          ovf_r[s][l]  <= ovf_r[s-1][l];
          base_r[s][l] <= base_r[s-1][l];
        end
      end
      out_res_r <= out_res_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

endmodule
`default_nettype wire

// ----- hdl/closest_point_on_triangle_3d.sv -----
// closest point on a triangle, fully pipelined top level
// throughput: one item per cycle unless a result waits on out_tready; the 33-stage restoring divider sets the depth
// the whole pipeline stalls as one while a result waits on out_tready
// reset (rst_n low, synchronous) clears every valid bit; data registers keep contents
`default_nettype none
module closest_point_on_triangle_3d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // query_x, query_y, query_z, corner_a_x..z, corner_b_x..z, corner_c_x..z
  input  logic [cpt_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // nearest_x, nearest_y, nearest_z
  output logic [cpt_pkg::OUT_W-1:0]   out_tdata
);

  localparam int CW  = cpt_pkg::COORD_W;
  localparam int LS  = cpt_pkg::LIMB_STEP;
  localparam int NL  = cpt_pkg::DET_LIMBS;
  localparam int SL  = cpt_pkg::S_LIMBS;
  localparam int TW  = cpt_pkg::PP_W + 1;
  // operand pairs of the six determinant products
  localparam int MX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int MY [6] = '{3, 1, 1, 5, 5, 3};

  logic en;
  logic [12:1] vld_r;

  cpt_pkg::coord_t p [3], ca [3], cb [3], cc [3];

  // corners and edge vectors carried to the select stage
  cpt_pkg::coord_t a_r  [1:8][3];
  cpt_pkg::coord_t b_r  [1:8][3];
  cpt_pkg::coord_t c_r  [1:8][3];
  cpt_pkg::diff_t  ab_r [1:8][3];
  cpt_pkg::diff_t  ac_r [1:8][3];
  cpt_pkg::diff_t  cbv_r[1:8][3];
  cpt_pkg::diff_t  ap_r [3], bp_r [3], cp_r [3];

  cpt_pkg::pp_t    ppd_r  [6][3];
  cpt_pkg::pp_t    ppd_nxt[6][3];
  cpt_pkg::dot_t   d_r    [3:7][6];
  cpt_pkg::dot_t   d_nxt  [6];
  cpt_pkg::pp_t    ppm_r  [6][NL][NL];
  cpt_pkg::pp_t    ppm_nxt[6][NL][NL];
  cpt_pkg::prod_t  row_r  [6][NL];
  cpt_pkg::prod_t  row_nxt[6][NL];
  cpt_pkg::prod_t  prod_r [6];
  cpt_pkg::prod_t  prod_nxt[6];
  cpt_pkg::det_t   va_r, vb_r, vc_r;
  cpt_pkg::edge_t  e43_r, e56_r;

  // select stage
  logic            force8_r, force8_nxt;
  cpt_pkg::coord_t base8_r [3], base8_nxt [3];
  cpt_pkg::coord_t a8_r [3];
  cpt_pkg::diff_t  u_r [3], u_nxt [3], v_r [3], v_nxt [3];
  cpt_pkg::det_t   s_r, s_nxt, t_r, t_nxt;
  cpt_pkg::den_t   den8_r, den8_nxt;

  // numerator stages
  cpt_pkg::pp_t    ppn_r  [3][2][SL];
  cpt_pkg::pp_t    ppn_nxt[3][2][SL];
  logic signed [TW-1:0] tsum_r [3][SL];
  logic signed [TW-1:0] tsum_nxt[3][SL];
  cpt_pkg::num_t   lo_r [3], lo_nxt [3], hi_r [3], hi_nxt [3];
  logic            force_r [9:12];
  cpt_pkg::den_t   den_r [9:12];
  cpt_pkg::coord_t base_r [9:12][3];
  logic            force9_nxt;
  cpt_pkg::coord_t base9_nxt [3];
  cpt_pkg::div_in_t [2:0] div_r;
  cpt_pkg::div_in_t [2:0] div_nxt;

  // whole pipeline moves while the output register is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack the item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i]  = in_tdata[CW*i       +: CW];
      ca[i] = in_tdata[CW*(3 + i) +: CW];
      cb[i] = in_tdata[CW*(6 + i) +: CW];
      cc[i] = in_tdata[CW*(9 + i) +: CW];
    end
  end

  // dot-product terms: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ppd_nxt[0][i] = ab_r[1][i] * ap_r[i];
      ppd_nxt[1][i] = ac_r[1][i] * ap_r[i];
      ppd_nxt[2][i] = ab_r[1][i] * bp_r[i];
      ppd_nxt[3][i] = ac_r[1][i] * bp_r[i];
      ppd_nxt[4][i] = ab_r[1][i] * cp_r[i];
      ppd_nxt[5][i] = ac_r[1][i] * cp_r[i];
    end
    for (int k = 0; k < 6; k++) begin
      d_nxt[k] = cpt_pkg::DOT_W'(ppd_r[k][0]) + cpt_pkg::DOT_W'(ppd_r[k][1])
               + cpt_pkg::DOT_W'(ppd_r[k][2]);
    end
  end

  // limb products, rows and full determinant products
  always_comb begin
    cpt_pkg::prod_t acc;
    for (int m = 0; m < 6; m++) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          ppm_nxt[m][i][j] =
            cpt_pkg::limb(cpt_pkg::WIDE_W'(d_r[3][MX[m]]), i, NL)
            * cpt_pkg::limb(cpt_pkg::WIDE_W'(d_r[3][MY[m]]), j, NL);
        end
      end
      for (int i = 0; i < NL; i++) begin
        acc = '0;
        for (int j = 0; j < NL; j++) begin
          acc = acc + (cpt_pkg::PROD_W'(ppm_r[m][i][j]) << (LS * j));
        end
        row_nxt[m][i] = acc;
      end
      acc = '0;
      for (int i = 0; i < NL; i++) begin
        acc = acc + (row_r[m][i] << (LS * i));
      end
      prod_nxt[m] = acc;
    end
  end

  // region tests in test order and choice of numerator, divisor and base
  always_comb begin
    cpt_pkg::dot_t d1, d2, d3, d4, d5, d6;
    d1 = d_r[7][0];
    d2 = d_r[7][1];
    d3 = d_r[7][2];
    d4 = d_r[7][3];
    d5 = d_r[7][4];
    d6 = d_r[7][5];
    force8_nxt = 1'b0;
    s_nxt      = '0;
    t_nxt      = '0;
    den8_nxt   = '0;
    for (int i = 0; i < 3; i++) begin
      base8_nxt[i] = a_r[7][i];
      u_nxt[i]     = ab_r[7][i];
      v_nxt[i]     = '0;
    end
    if (d1 <= 0 && d2 <= 0) begin
      force8_nxt = 1'b1;
    end else if (d3 >= 0 && e43_r <= 0) begin
      force8_nxt = 1'b1;
      base8_nxt  = b_r[7];
    end else if (vc_r <= 0 && d1 >= 0 && d3 <= 0) begin
      s_nxt    = cpt_pkg::DET_W'(d1);
      den8_nxt = cpt_pkg::DEN_W'(d1) - cpt_pkg::DEN_W'(d3);
    end else if (d6 >= 0 && e56_r <= 0) begin
      force8_nxt = 1'b1;
      base8_nxt  = c_r[7];
    end else if (vb_r <= 0 && d2 >= 0 && d6 <= 0) begin
      u_nxt    = ac_r[7];
      s_nxt    = cpt_pkg::DET_W'(d2);
      den8_nxt = cpt_pkg::DEN_W'(d2) - cpt_pkg::DEN_W'(d6);
    end else if (va_r <= 0 && e43_r >= 0 && e56_r >= 0) begin
      base8_nxt = b_r[7];
      u_nxt     = cbv_r[7];
      s_nxt     = cpt_pkg::DET_W'(e43_r);
      den8_nxt  = cpt_pkg::DEN_W'(e43_r) + cpt_pkg::DEN_W'(e56_r);
    end else begin
      v_nxt    = ac_r[7];
      s_nxt    = vb_r;
      t_nxt    = vc_r;
      den8_nxt = cpt_pkg::DEN_W'(va_r) + cpt_pkg::DEN_W'(vb_r) + cpt_pkg::DEN_W'(vc_r);
    end
  end

  // numerator limb products, zero-divisor fallback to corner a
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < SL; k++) begin
        ppn_nxt[c][0][k] = u_r[c] * cpt_pkg::limb(cpt_pkg::WIDE_W'(s_r), k, SL);
        ppn_nxt[c][1][k] = v_r[c] * cpt_pkg::limb(cpt_pkg::WIDE_W'(t_r), k, SL);
      end
    end
    force9_nxt = force8_r || (den8_r == '0);
    for (int c = 0; c < 3; c++) begin
      base9_nxt[c] = (!force8_r && den8_r == '0) ? a8_r[c] : base8_r[c];
    end
  end

  // numerator summation in three steps
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < SL; k++) begin
        tsum_nxt[c][k] = TW'(ppn_r[c][0][k]) + TW'(ppn_r[c][1][k]);
      end
      lo_nxt[c] = cpt_pkg::NUM_W'(tsum_r[c][0])
                + (cpt_pkg::NUM_W'(tsum_r[c][1]) << LS)
                + (cpt_pkg::NUM_W'(tsum_r[c][2]) << (2 * LS));
      hi_nxt[c] = cpt_pkg::NUM_W'(tsum_r[c][3])
                + (cpt_pkg::NUM_W'(tsum_r[c][4]) << LS);
      div_nxt[c].num        = lo_r[c] + (hi_r[c] << (3 * LS));
      div_nxt[c].den        = den_r[11];
      div_nxt[c].base       = base_r[11][c];
      div_nxt[c].force_base = force_r[11];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[11:1], in_tvalid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      // differences
      for (int i = 0; i < 3; i++) begin
        a_r[1][i]   <= ca[i];
        b_r[1][i]   <= cb[i];
        c_r[1][i]   <= cc[i];
        ab_r[1][i]  <= cpt_pkg::DIFF_W'(cb[i]) - cpt_pkg::DIFF_W'(ca[i]);
        ac_r[1][i]  <= cpt_pkg::DIFF_W'(cc[i]) - cpt_pkg::DIFF_W'(ca[i]);
        cbv_r[1][i] <= cpt_pkg::DIFF_W'(cc[i]) - cpt_pkg::DIFF_W'(cb[i]);
        ap_r[i]     <= cpt_pkg::DIFF_W'(p[i]) - cpt_pkg::DIFF_W'(ca[i]);
        bp_r[i]     <= cpt_pkg::DIFF_W'(p[i]) - cpt_pkg::DIFF_W'(cb[i]);
        cp_r[i]     <= cpt_pkg::DIFF_W'(p[i]) - cpt_pkg::DIFF_W'(cc[i]);
      end
      for (int k = 2; k <= 8; k++) begin
        a_r[k]   <= a_r[k-1];
        b_r[k]   <= b_r[k-1];
        c_r[k]   <= c_r[k-1];
        ab_r[k]  <= ab_r[k-1];
        ac_r[k]  <= ac_r[k-1];
        cbv_r[k] <= cbv_r[k-1];
      end
      // dot products
      ppd_r  <= ppd_nxt;
      d_r[3] <= d_nxt;
      for (int k = 4; k <= 7; k++) begin
        d_r[k] <= d_r[k-1];
      end
      // determinants
      ppm_r  <= ppm_nxt;
      row_r  <= row_nxt;
      prod_r <= prod_nxt;
      vc_r   <= cpt_pkg::DET_W'(prod_r[0]) - cpt_pkg::DET_W'(prod_r[1]);
      vb_r   <= cpt_pkg::DET_W'(prod_r[2]) - cpt_pkg::DET_W'(prod_r[3]);
      va_r   <= cpt_pkg::DET_W'(prod_r[4]) - cpt_pkg::DET_W'(prod_r[5]);
      e43_r  <= cpt_pkg::EDGE_W'(d_r[6][3]) - cpt_pkg::EDGE_W'(d_r[6][2]);
      e56_r  <= cpt_pkg::EDGE_W'(d_r[6][4]) - cpt_pkg::EDGE_W'(d_r[6][5]);
      // select
      force8_r <= force8_nxt;
      base8_r  <= base8_nxt;
      a8_r     <= a_r[7];
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      s_r      <= s_nxt;
      t_r      <= t_nxt;
      den8_r   <= den8_nxt;
      // numerator
      ppn_r      <= ppn_nxt;
      force_r[9] <= force9_nxt;
      den_r[9]   <= den8_r;
      base_r[9]  <= base9_nxt;
      for (int k = 10; k <= 12; k++) begin
        force_r[k] <= force_r[k-1];
        den_r[k]   <= den_r[k-1];
        base_r[k]  <= base_r[k-1];
      end
      tsum_r <= tsum_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      div_r  <= div_nxt;
    end
  end

  // divide, add base and saturate
  cpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[12]),
    .in_lane (div_r),
    .out_vld (out_tvalid),
    .out_res (out_tdata)
  );

endmodule
`default_nettype wire

// ----- hdl/cpt_chk.sv -----
// port-level checker for the closest-point pipeline, bound to the top level
`default_nettype none
module cpt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [cpt_pkg::IN_W-1:0]    in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [cpt_pkg::OUT_W-1:0]   out_tdata
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // reset leaves no result on the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // input is taken exactly when the output register is free or draining
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // input item is taken only with its valid, and the payload is known then
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown(in_tdata))
    else $error("unknown item accepted");

endmodule

bind closest_point_on_triangle_3d cpt_chk u_cpt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
